>>> rtl/bemf_pkg.sv
// Shared types and constants for the six-step commutation core.
`timescale 1ns / 1ps

package bemf_pkg;

  // Request codes carried on the input channel
  localparam logic [1:0] REQ_SAMPLE   = 2'd0;
  localparam logic [1:0] REQ_ZERO_X   = 2'd1;
  localparam logic [1:0] REQ_COMMUTE  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_BAD_LIMIT = 2'd1;
  localparam logic [1:0] REG_ADVANCE   = 2'd2;
  localparam logic [1:0] REG_INVERT    = 2'd3;

  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_LAST  = 3'd6;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  typedef struct packed {
    logic [2:0]  step_now;
    logic        edge_rising;
    logic [7:0]  good_sample_count;
    logic [15:0] interval_filtered;
    logic [15:0] wait_ticks;
    logic        wrapped;
    logic [7:0]  zero_cross_total;
  } result_t;

endpackage

>>> rtl/bemf_six_step_commutator.sv
// Top level of the sensorless six-step commutation core.
`timescale 1ns / 1ps

// Sensorless BLDC six-step commutation core.
//
// Input channel (in_valid/in_ready) carries one request per transfer: a
// comparator sample, a found zero crossing, or a commutate command. Every
// request yields exactly one result on the output channel (out_valid/
// out_ready) reporting the step, expected edge, sample counters, filtered
// interval and the wait from zero crossing to commutation.
//
// The state registers update at the edge that accepts the request, and the
// result enters the output entry, or the skid entry if that one is held.
// Throughput is one request per cycle while in_ready is high; the step/counter
// state loop and the 6 x INTERVAL_BITS advance multiply are combinational.
//
// A result register plus one skid entry separate the channels, so a request
// is still taken while one result waits on a stalled receiver; in_ready
// drops only once both entries are full.
//
// rst_n (synchronous) empties the output entries and loads the state and the
// registers with their defaults. The APB-style port must be written only while
// the core is idle (not enforced here); reads return the register values.
module bemf_six_step_commutator #(
  parameter int INTERVAL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic        in_comp_level,
  input  logic [15:0] in_timer_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_step_now,
  output logic        out_edge_rising,
  output logic [7:0]  out_good_sample_count,
  output logic [15:0] out_interval_filtered,
  output logic [15:0] out_wait_ticks,
  output logic        out_wrapped,
  output logic [7:0]  out_zero_cross_total,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bemf_pkg::*;

  localparam int IB = INTERVAL_BITS;
  // common width holding both the timer input and the interval
  localparam int CW = (IB > 16) ? IB : 16;

  // configuration registers
  logic       direction_r;
  logic [7:0] bad_limit_r;
  logic [5:0] advance_r;
  logic       invert_r;

  // core state
  logic [2:0]    step_r,     step_nxt;
  logic          rising_r,   rising_nxt;
  logic [7:0]    good_r,     good_nxt;
  logic [7:0]    bad_r,      bad_nxt;
  logic [IB-1:0] interval_r, interval_nxt;
  logic [7:0]    zc_r,       zc_nxt;

  // output entry and skid entry
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r, res;

  logic in_fire, out_fire, cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;

  // ---------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b1;
      bad_limit_r <= 8'd2;
      advance_r   <= 6'd16;
      invert_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DIRECTION: direction_r <= pwdata[0];
        REG_BAD_LIMIT: bad_limit_r <= pwdata[7:0];
        REG_ADVANCE:   advance_r   <= pwdata[5:0];
        REG_INVERT:    invert_r    <= pwdata[0];
        default:       direction_r <= direction_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DIRECTION: prdata = {31'd0, direction_r};
      REG_BAD_LIMIT: prdata = {24'd0, bad_limit_r};
      REG_ADVANCE:   prdata = {26'd0, advance_r};
      REG_INVERT:    prdata = {31'd0, invert_r};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Zero-crossing arithmetic: filter, half interval, advance, wait
  // ---------------------------------------------------------------
  logic [CW-1:0]   tcount_ext, imask_ext, fresh_ext;
  logic [IB+1:0]   filt_sum;
  logic [IB-1:0]   filt, half, adv, wait_full;
  logic [IB+5:0]   adv_prod;
  logic [CW-1:0]   wait_ext, interval_ext;

  always_comb begin
    tcount_ext = CW'(in_timer_count);
    imask_ext  = CW'({IB{1'b1}});
    // clamp a timer value that does not fit the interval width
    fresh_ext  = (tcount_ext > imask_ext) ? imask_ext : tcount_ext;
    // (fresh + 3*old) / 4, never exceeds the interval range
    filt_sum   = {2'b00, fresh_ext[IB-1:0]} + {1'b0, interval_r, 1'b0}
               + {2'b00, interval_r};
    filt       = filt_sum[IB+1:2];
    half       = filt >> 1;
    adv_prod   = {{IB{1'b0}}, advance_r} * {6'd0, filt};
    adv        = adv_prod[IB+5:6];
    // saturate at zero when the advance exceeds the half interval
    wait_full  = (half > adv) ? (half - adv) : '0;
  end

  // ---------------------------------------------------------------
  // Commutation: next step, wrap flag and expected edge
  // ---------------------------------------------------------------
  logic [2:0] comm_step;
  logic       comm_wrap, comm_rising;

  always_comb begin
    if (direction_r) begin
      comm_wrap   = (step_r >= STEP_LAST);
      comm_step   = comm_wrap ? STEP_FIRST : step_r + 3'd1;
      comm_rising = comm_step[0];
    end else begin
      comm_wrap   = (step_r <= STEP_FIRST);
      comm_step   = comm_wrap ? STEP_LAST : step_r - 3'd1;
      comm_rising = ~comm_step[0];
    end
    comm_rising = comm_rising ^ invert_r;
  end

  // ---------------------------------------------------------------
  // Request decode and state update
  // ---------------------------------------------------------------
  logic [7:0] bad_inc;
  logic       wrap_bit;
  logic [IB-1:0] wait_sel;

  assign bad_inc = (bad_r < COUNT_MAX) ? bad_r + 8'd1 : COUNT_MAX;

  always_comb begin
    step_nxt     = step_r;
    rising_nxt   = rising_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    interval_nxt = interval_r;
    zc_nxt       = zc_r;
    wrap_bit     = 1'b0;
    wait_sel     = '0;
    case (in_req_type)
      REQ_SAMPLE: begin
        if (in_comp_level == rising_r) begin
          good_nxt = (good_r < COUNT_MAX) ? good_r + 8'd1 : COUNT_MAX;
        end else begin
          bad_nxt = bad_inc;
          // past the tolerance, each bad sample drops the good run
          if (bad_inc > bad_limit_r) begin
            good_nxt = 8'd0;
          end
        end
      end
      REQ_ZERO_X: begin
        interval_nxt = filt;
        wait_sel     = wait_full;
        step_nxt     = comm_step;
        rising_nxt   = comm_rising;
        wrap_bit     = comm_wrap;
        good_nxt     = 8'd0;
        bad_nxt      = 8'd0;
        zc_nxt       = (zc_r < COUNT_MAX) ? zc_r + 8'd1 : COUNT_MAX;
      end
      REQ_COMMUTE: begin
        step_nxt   = comm_step;
        rising_nxt = comm_rising;
        wrap_bit   = comm_wrap;
        good_nxt   = 8'd0;
      end
      default: begin
        // unused code: report state unchanged
        wrap_bit = 1'b0;
      end
    endcase
  end

  always_comb begin
    wait_ext                = CW'(wait_sel);
    interval_ext            = CW'(interval_nxt);
    res.step_now            = step_nxt;
    res.edge_rising         = rising_nxt;
    res.good_sample_count   = good_nxt;
    res.interval_filtered   = interval_ext[15:0];
    res.wait_ticks          = wait_ext[15:0];
    res.wrapped             = wrap_bit;
    res.zero_cross_total    = zc_nxt;
  end

  // Advance the state on every accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= STEP_FIRST;
      rising_r   <= 1'b1;
      good_r     <= 8'd0;
      bad_r      <= 8'd0;
      interval_r <= '0;
      zc_r       <= 8'd0;
    end else if (in_fire) begin
      step_r     <= step_nxt;
      rising_r   <= rising_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
      interval_r <= interval_nxt;
      zc_r       <= zc_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Output entry with one skid entry behind it
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      // output entry free: refill from skid first, else from the new result
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      // receiver stalled: hold the new result in the skid entry
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_step_now          = out_r.step_now;
  assign out_edge_rising       = out_r.edge_rising;
  assign out_good_sample_count = out_r.good_sample_count;
  assign out_interval_filtered = out_r.interval_filtered;
  assign out_wait_ticks        = out_r.wait_ticks;
  assign out_wrapped           = out_r.wrapped;
  assign out_zero_cross_total  = out_r.zero_cross_total;

endmodule

>>> rtl/bemf_checker.sv
// Port-level checks for the six-step commutation core, bound to its top level.
`timescale 1ns / 1ps

module bemf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_step_now,
  input logic        out_wrapped,
  input logic [7:0]  out_zero_cross_total,
  input logic [15:0] out_wait_ticks
);
  import bemf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_now)
      && $stable(out_wait_ticks) && $stable(out_zero_cross_total))
    else $error("stalled result changed");

  // step stays in the six-state sequence
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_now >= STEP_FIRST) && (out_step_now <= STEP_LAST))
    else $error("step out of range");

  // a wrap lands on an end of the sequence
  a_wrap_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrapped |-> (out_step_now == STEP_FIRST) || (out_step_now == STEP_LAST))
    else $error("wrap flagged away from sequence end");

  // back-pressure only when a result is already waiting
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready && out_valid && !in_ready))
    else $error("input stalled without a pending result");

endmodule

bind bemf_six_step_commutator bemf_checker u_bemf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_step_now         (out_step_now),
  .out_wrapped          (out_wrapped),
  .out_zero_cross_total (out_zero_cross_total),
  .out_wait_ticks       (out_wait_ticks)
);
